/* rtl/cmdtw_pkg.sv */
package cmdtw_pkg;

  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned RET_W   = 20;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned WORD_W  = 16;

  localparam logic [WORD_W-1:0] END_BIT   = 16'h8000;
  localparam logic [WORD_W-1:0] BAD_MASK  = 16'h000C;
  localparam logic [WORD_W-1:0] JUMP_MASK = 16'h3000;

  localparam logic [RET_W-1:0] ENTRY_SIZE = 20'h00020;
  localparam logic [RET_W-1:0] ADDR_LIMIT = 20'h7FFE0;

  typedef enum logic [1:0] {
    ST_FETCH   = 2'd0,
    ST_FOUND   = 2'd1,
    ST_END     = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_JUMP = 2'd1,
    JMP_CALL = 2'd2,
    JMP_RET  = 2'd3
  } jump_t;

endpackage

/* rtl/command_table_walker_core.sv */
// m_tvalid rises in the cycle after a request is accepted.
// Throughput: one request per cycle while m_tready is high; the output
// register drains while the next request is taken. In a walk, the rate is set
// by the fetch round trip of the entry at the address just returned.
// Reset (rst, synchronous): clears the walk state, the target index and the
// output valid.
module command_table_walker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // target_index
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // [15:0] ctrl_word, [31:16] link_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,       // [18:0] next_address, [23:19] zero
  output logic [1:0]  m_tuser        // [1:0] status
);

  localparam int unsigned AW = cmdtw_pkg::ADDR_W;
  localparam int unsigned RW = cmdtw_pkg::RET_W;
  localparam int unsigned CW = cmdtw_pkg::COUNT_W;

  logic [CW-1:0] target_index;
  logic [AW-1:0] current_address;
  logic [RW-1:0] return_address;
  logic          return_held;
  logic [CW-1:0] command_count;

  logic [AW-1:0] current_address_next;
  logic [RW-1:0] return_address_next;
  logic          return_held_next;
  logic [CW-1:0] command_count_next;

  logic [AW-1:0]      out_addr;
  cmdtw_pkg::status_t out_status;

  logic [15:0]      ctrl_word;
  logic [15:0]      link_word;
  logic             accept;
  logic [RW-1:0]    seq_addr;
  logic [RW-1:0]    link_addr;
  logic [RW-1:0]    next;
  cmdtw_pkg::jump_t jmode;

  assign ctrl_word = s_tdata[15:0];
  assign link_word = s_tdata[31:16];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign seq_addr  = {1'b0, current_address} + cmdtw_pkg::ENTRY_SIZE;
  assign link_addr = {1'b0, link_word, 3'b000};
  assign jmode     = cmdtw_pkg::jump_t'(ctrl_word[13:12]);

  always_comb begin
    current_address_next = current_address;
    return_address_next  = return_address;
    return_held_next     = return_held;
    command_count_next   = command_count;
    out_addr             = '0;
    out_status           = cmdtw_pkg::ST_FETCH;
    next                 = seq_addr;

    case (jmode)
      cmdtw_pkg::JMP_NEXT: next = seq_addr;
      cmdtw_pkg::JMP_JUMP: next = link_addr;
      cmdtw_pkg::JMP_CALL: begin
        next = link_addr;
        if (!return_held) begin
          return_address_next = seq_addr;
          return_held_next    = 1'b1;
        end
      end
      cmdtw_pkg::JMP_RET: begin
        if (return_held) begin
          next                = return_address;
          return_held_next    = 1'b0;
          return_address_next = '0;
        end else begin
          next = seq_addr;
        end
      end
      default: next = seq_addr;
    endcase

    if (command_count == target_index) begin
      out_status = cmdtw_pkg::ST_FOUND;
      out_addr   = current_address;
    end else if ((ctrl_word & cmdtw_pkg::END_BIT) != '0) begin
      out_status = cmdtw_pkg::ST_END;
    end else if ((ctrl_word & cmdtw_pkg::BAD_MASK) == cmdtw_pkg::BAD_MASK) begin
      out_status = cmdtw_pkg::ST_INVALID;
    end else if (next > cmdtw_pkg::ADDR_LIMIT) begin
      out_status = cmdtw_pkg::ST_INVALID;
    end else begin
      out_status           = cmdtw_pkg::ST_FETCH;
      out_addr             = next[AW-1:0];
      current_address_next = next[AW-1:0];
      command_count_next   = command_count + CW'(1);
    end

    if (out_status != cmdtw_pkg::ST_FETCH) begin
      current_address_next = '0;
      return_address_next  = '0;
      return_held_next     = 1'b0;
      command_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_index    <= '0;
      current_address <= '0;
      return_address  <= '0;
      return_held     <= 1'b0;
      command_count   <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_index <= cfg_wr_data;
      end
      if (accept) begin
        current_address <= current_address_next;
        return_address  <= return_address_next;
        return_held     <= return_held_next;
        command_count   <= command_count_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, out_addr};
      m_tuser <= out_status;
    end
  end

  // terminal result returns walk state to reset
  assert property (@(posedge clk) disable iff (rst)
    accept && out_status != cmdtw_pkg::ST_FETCH
    |=> current_address == '0 && !return_held && command_count == '0)
    else $error("walk state not cleared after terminal result");

  assert property (@(posedge clk) disable iff (rst)
    !return_held |-> return_address == '0)
    else $error("return address set while none held");

  assert property (@(posedge clk) disable iff (rst)
    {1'b0, current_address} <= cmdtw_pkg::ADDR_LIMIT)
    else $error("current address beyond table limit");

  // a stalled fetch request points at the entry now being examined
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && m_tuser == cmdtw_pkg::ST_FETCH
    |-> m_tdata[AW-1:0] == current_address)
    else $error("pending fetch address differs from walk state");

endmodule
